// ===== sv/osva_pkg.sv =====
// ----------------------------------------------------------------------------
// osva_pkg
// Shared widths, codes and controller/datapath interface types for the
// oldest-steal voice allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package osva_pkg;

  localparam int unsigned SlotW    = 4;
  localparam int unsigned TagW     = 8;
  localparam int unsigned StampW   = 32;
  localparam int unsigned CfgW     = 5;
  localparam int unsigned SlotSpan = 16;

  localparam logic [CfgW-1:0] MaxVoicesRst = 5'd16;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef struct packed {
    logic capture;
    logic rel_rd;
    logic alloc_free;
    logic scan_start;
    logic scan_rd;
    logic steal;
    logic rel_chk;
    logic load_out;
  } osva_cmd_t;

  typedef struct packed {
    logic is_release;
    logic has_free;
    logic scan_last;
    logic out_busy;
  } osva_sts_t;

endpackage

`default_nettype wire

// ===== sv/osva_ctrl.sv =====
// ----------------------------------------------------------------------------
// osva_ctrl
// Sequencer for the voice allocator: dispatch, stamp scan, steal, release
// check and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module osva_ctrl
  import osva_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire osva_sts_t sts_i,
  output osva_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_SCAN_END,
    ST_STEAL,
    ST_REL_CHK,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (sts_i.is_release) begin
          cmd_o.rel_rd = 1'b1;
          state_d      = ST_REL_CHK;
        end else if (sts_i.has_free) begin
          cmd_o.alloc_free = 1'b1;
          state_d          = ST_FINISH;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        state_d = ST_STEAL;
      end
      ST_STEAL: begin
        cmd_o.steal = 1'b1;
        state_d     = ST_FINISH;
      end
      ST_REL_CHK: begin
        cmd_o.rel_chk = 1'b1;
        state_d       = ST_FINISH;
      end
      ST_FINISH: begin
        if (!sts_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/osva_dp.sv =====
// ----------------------------------------------------------------------------
// osva_dp
// Slot table, voice limit register, free search, oldest-stamp scan, release
// match and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module osva_dp
  import osva_pkg::*;
#(
  parameter int unsigned MAX_VOICES = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire osva_cmd_t         cmd_i,
  output osva_sts_t              sts_o,
  input  wire logic              op_i,
  input  wire logic [TagW-1:0]   owner_tag_i,
  input  wire logic [SlotW-1:0]  release_slot_i,
  input  wire logic [StampW-1:0] now_stamp_i,
  input  wire logic              cfg_we_i,
  input  wire logic [CfgW-1:0]   cfg_wdata_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [SlotW-1:0]       slot_o,
  output logic                   stole_o,
  output logic [TagW-1:0]        evicted_owner_o,
  output logic                   release_done_o
);

  localparam int unsigned TableDepth = (MAX_VOICES < SlotSpan) ? MAX_VOICES : SlotSpan;
  localparam int unsigned IdxW       = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam logic [CfgW-1:0] DepthC = CfgW'(TableDepth);

  logic [StampW-1:0] stamp_mem [TableDepth];
  logic [TagW-1:0]   owner_mem [TableDepth];
  logic [TableDepth-1:0] valid_q;

  logic [CfgW-1:0]   max_voices_q;
  logic              op_q;
  logic [TagW-1:0]   tag_q;
  logic [SlotW-1:0]  rel_q;
  logic [StampW-1:0] now_q;

  logic [IdxW-1:0]   cnt_q;
  logic              rd_vld_q;
  logic [IdxW-1:0]   rd_idx_q;
  logic [StampW-1:0] stamp_rd_q;
  logic [TagW-1:0]   owner_rd_q;
  logic [StampW-1:0] best_stamp_q;
  logic [IdxW-1:0]   best_idx_q;
  logic [TagW-1:0]   best_owner_q;

  logic [SlotW-1:0]  res_slot_q;
  logic              res_stole_q;
  logic [TagW-1:0]   res_evicted_q;
  logic              res_done_q;
  logic              out_valid_q;

  logic [CfgW-1:0]   lim;
  logic              free_found;
  logic [IdxW-1:0]   free_idx;
  logic              rd_en;
  logic [IdxW-1:0]   rd_addr;
  logic              wr_en;
  logic [IdxW-1:0]   wr_idx;
  logic              rel_in_range;
  logic [IdxW-1:0]   rel_idx;
  logic              rel_ok;

  // clamp the voice limit to 1 .. table depth
  always_comb begin
    lim = max_voices_q;
    if (lim == '0) begin
      lim = CfgW'(1);
    end
    if (lim > DepthC) begin
      lim = DepthC;
    end
  end

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TableDepth - 1; i >= 0; i--) begin
      if (!valid_q[i] && (CfgW'(i) < lim)) begin
        free_found = 1'b1;
        free_idx   = IdxW'(i);
      end
    end
  end

  assign rel_in_range = (CfgW'(rel_q) < DepthC);
  assign rel_idx      = rel_q[IdxW-1:0];
  assign rel_ok       = rel_in_range && valid_q[rel_idx] && (owner_rd_q == tag_q);

  assign rd_en   = cmd_i.scan_rd | cmd_i.rel_rd;
  assign rd_addr = cmd_i.scan_rd ? cnt_q : rel_idx;
  assign wr_en   = cmd_i.alloc_free | cmd_i.steal;
  assign wr_idx  = cmd_i.alloc_free ? free_idx : best_idx_q;

  assign sts_o.is_release = (op_q == OP_RELEASE);
  assign sts_o.has_free   = free_found;
  assign sts_o.scan_last  = (CfgW'(cnt_q) == (lim - CfgW'(1)));
  assign sts_o.out_busy   = out_valid_q & ~out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_voices_q <= MaxVoicesRst;
    end else if (cfg_we_i) begin
      max_voices_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= op_i;
      tag_q <= owner_tag_i;
      rel_q <= release_slot_i;
      now_q <= now_stamp_i;
    end
  end

  // slot table
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      owner_mem[wr_idx] <= tag_q;
      stamp_mem[wr_idx] <= now_q;
    end
    if (rd_en) begin
      owner_rd_q <= owner_mem[rd_addr];
      stamp_rd_q <= stamp_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (wr_en) begin
        valid_q[wr_idx] <= 1'b1;
      end
      if (cmd_i.rel_chk && rel_ok) begin
        valid_q[rel_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan_rd;
      if (cmd_i.scan_start) begin
        cnt_q <= '0;
      end else if (cmd_i.scan_rd) begin
        cnt_q <= cnt_q + IdxW'(1);
      end
    end
  end

  // track oldest stamp, lowest index wins ties
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_rd) begin
      rd_idx_q <= cnt_q;
    end
    if (rd_vld_q && ((rd_idx_q == '0) || (stamp_rd_q < best_stamp_q))) begin
      best_stamp_q <= stamp_rd_q;
      best_idx_q   <= rd_idx_q;
      best_owner_q <= owner_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc_free) begin
      res_slot_q    <= SlotW'(free_idx);
      res_stole_q   <= 1'b0;
      res_evicted_q <= '0;
      res_done_q    <= 1'b0;
    end else if (cmd_i.steal) begin
      res_slot_q    <= SlotW'(best_idx_q);
      res_stole_q   <= 1'b1;
      res_evicted_q <= best_owner_q;
      res_done_q    <= 1'b0;
    end else if (cmd_i.rel_chk) begin
      res_slot_q    <= '0;
      res_stole_q   <= 1'b0;
      res_evicted_q <= '0;
      res_done_q    <= rel_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      slot_o          <= res_slot_q;
      stole_o         <= res_stole_q;
      evicted_owner_o <= res_evicted_q;
      release_done_o  <= res_done_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== sv/oldest_steal_voice_allocator.sv =====
// ----------------------------------------------------------------------------
// oldest_steal_voice_allocator
// Polyphonic voice allocator: lowest free slot on allocate, oldest-stamp
// steal when full, owner-checked release.
//
//   channel   handshake                  payload
//   input     in_valid_i / in_ready_o    op, owner_tag, release_slot, now_stamp
//   output    out_valid_o / out_ready_i  slot, stole, evicted_owner, release_done
//   config    cfg_we_i                   cfg_wdata_i (max_voices)
//
// One transaction at a time. A steal takes longer than a free allocate or a
// release: it waits on the one-slot-per-cycle stamp scan of the slot table
// read port, which covers every slot below the voice limit. Reset frees every
// slot at once and sets the voice limit to 16. A result waiting in the output
// register does not block the next input transaction; only a second finished
// result stalls behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module oldest_steal_voice_allocator
  import osva_pkg::*;
#(
  parameter int unsigned MAX_VOICES = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              op_i,
  input  wire logic [TagW-1:0]   owner_tag_i,
  input  wire logic [SlotW-1:0]  release_slot_i,
  input  wire logic [StampW-1:0] now_stamp_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [SlotW-1:0]       slot_o,
  output logic                   stole_o,
  output logic [TagW-1:0]        evicted_owner_o,
  output logic                   release_done_o,
  input  wire logic              cfg_we_i,
  input  wire logic [CfgW-1:0]   cfg_wdata_i
);

  osva_cmd_t cmd;
  osva_sts_t sts;

  osva_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  osva_dp #(
    .MAX_VOICES (MAX_VOICES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .op_i            (op_i),
    .owner_tag_i     (owner_tag_i),
    .release_slot_i  (release_slot_i),
    .now_stamp_i     (now_stamp_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .slot_o          (slot_o),
    .stole_o         (stole_o),
    .evicted_owner_o (evicted_owner_o),
    .release_done_o  (release_done_o)
  );

endmodule

`default_nettype wire

// ===== verif/oldest_steal_voice_allocator_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// oldest_steal_voice_allocator_checker
// Watches the request, grant and limit ports of the voice allocator. It keeps
// its own copy of the slot table and the voice limit, predicts the grant of
// every accepted request, and compares each accepted grant field by field with
// the oldest prediction. Mismatches and unexpected grants are counted.
// ----------------------------------------------------------------------------
module oldest_steal_voice_allocator_checker
  import osva_pkg::*;
#(
  parameter int unsigned MAX_VOICES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic              op_i,
  input  logic [TagW-1:0]   owner_tag_i,
  input  logic [SlotW-1:0]  release_slot_i,
  input  logic [StampW-1:0] now_stamp_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [SlotW-1:0]  slot_i,
  input  logic              stole_i,
  input  logic [TagW-1:0]   evicted_owner_i,
  input  logic              release_done_i,
  input  logic              cfg_we_i,
  input  logic [CfgW-1:0]   cfg_wdata_i,
  output int                fail_count_o,
  output int                pending_o
);

  typedef struct packed {
    logic [SlotW-1:0] slot;
    logic             stole;
    logic [TagW-1:0]  evicted;
    logic             done;
  } voice_grant_t;

  voice_grant_t      grant_q[$];
  logic              slot_busy[MAX_VOICES];
  logic [TagW-1:0]   slot_tag[MAX_VOICES];
  logic [StampW-1:0] slot_time[MAX_VOICES];
  logic [CfgW-1:0]   voice_cfg;
  int                fails;

  assign fail_count_o = fails;

  function automatic int unsigned usable_voices();
    int unsigned lim;
    lim = (voice_cfg == '0) ? 32'd1 : 32'(voice_cfg);
    if (lim > MAX_VOICES) lim = MAX_VOICES;
    if (lim > SlotSpan) lim = SlotSpan;
    return lim;
  endfunction

  function automatic voice_grant_t serve_request(logic op, logic [TagW-1:0] tag,
                                                 logic [SlotW-1:0] rel,
                                                 logic [StampW-1:0] stamp);
    voice_grant_t    r;
    int unsigned     lim;
    int unsigned     pick;
    int unsigned     oldest;
    bit              found;
    logic [StampW:0] oldest_time;
    r = '0;
    if (op == OP_ALLOC) begin
      lim = usable_voices();
      pick = 0;
      oldest = 0;
      found = 1'b0;
      oldest_time = '1;
      for (int i = 0; i < lim; i++) begin
        if (!found) begin
          if (!slot_busy[i]) begin
            pick = i;
            found = 1'b1;
          end else if ({1'b0, slot_time[i]} < oldest_time) begin
            oldest = i;
            oldest_time = {1'b0, slot_time[i]};
          end
        end
      end
      if (!found) begin
        pick = oldest;
        r.stole = 1'b1;
        r.evicted = slot_tag[pick];
      end
      slot_busy[pick] = 1'b1;
      slot_tag[pick] = tag;
      slot_time[pick] = stamp;
      r.slot = pick[SlotW-1:0];
    end else if (rel < MAX_VOICES && slot_busy[rel] && slot_tag[rel] == tag) begin
      slot_busy[rel] = 1'b0;
      r.done = 1'b1;
    end
    return r;
  endfunction

  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    voice_grant_t want;
    if (!rst_ni) begin
      grant_q.delete();
      voice_cfg = MaxVoicesRst;
      fails = 0;
      for (int i = 0; i < MAX_VOICES; i++) begin
        slot_busy[i] = 1'b0;
        slot_tag[i] = '0;
        slot_time[i] = '0;
      end
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (grant_q.size() == 0) begin
          $display("%0t: unexpected grant, expected none actual slot %0h stole %0b",
                   $time, slot_i, stole_i);
          fails++;
        end else begin
          want = grant_q.pop_front();
          compare_field("slot", 32'(want.slot), 32'(slot_i));
          compare_field("stole", 32'(want.stole), 32'(stole_i));
          compare_field("evicted_owner", 32'(want.evicted), 32'(evicted_owner_i));
          compare_field("release_done", 32'(want.done), 32'(release_done_i));
        end
      end
      if (cfg_we_i) voice_cfg = cfg_wdata_i;
      if (in_valid_i && in_ready_i) begin
        grant_q.push_back(serve_request(op_i, owner_tag_i, release_slot_i, now_stamp_i));
      end
      pending_o <= grant_q.size();
    end
  end

endmodule

// ===== verif/oldest_steal_voice_allocator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// oldest_steal_voice_allocator_tb
// Drives note requests and releases into the voice allocator under a range of
// voice limits: a directed part for free grants, steals with stamp ties,
// owner-checked releases and out-of-range limits, then random traffic built
// mostly from a small pool of owner tags so releases hit held voices. Both
// channels stall at random; a checker beside the block predicts every grant.
// ----------------------------------------------------------------------------
module oldest_steal_voice_allocator_tb;
  import osva_pkg::*;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              op = OP_ALLOC;
  logic [TagW-1:0]   owner_tag = '0;
  logic [SlotW-1:0]  release_slot = '0;
  logic [StampW-1:0] now_stamp = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [SlotW-1:0]  slot;
  logic              stole;
  logic [TagW-1:0]   evicted_owner;
  logic              release_done;
  logic              cfg_we = 1'b0;
  logic [CfgW-1:0]   cfg_wdata = '0;
  int                fail_count;
  int                pending;

  int unsigned       idle_mode = 0;
  bit                hold_kick = 1'b0;
  int unsigned       hold_left = 0;
  logic [StampW-1:0] stamp_now = 32'd1000;
  logic [TagW-1:0]   tag_pool[8];

  oldest_steal_voice_allocator u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .op_i           (op),
    .owner_tag_i    (owner_tag),
    .release_slot_i (release_slot),
    .now_stamp_i    (now_stamp),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .slot_o         (slot),
    .stole_o        (stole),
    .evicted_owner_o(evicted_owner),
    .release_done_o (release_done),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata)
  );

  oldest_steal_voice_allocator_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .op_i           (op),
    .owner_tag_i    (owner_tag),
    .release_slot_i (release_slot),
    .now_stamp_i    (now_stamp),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .slot_i         (slot),
    .stole_i        (stole),
    .evicted_owner_i(evicted_owner),
    .release_done_i (release_done),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // hold off the grant channel for a long stretch on request
  always @(posedge clk_i) begin
    if (hold_kick) begin
      hold_left = 120;
      hold_kick = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (idle_mode)
        1: begin
          out_ready <= ($urandom_range(0, 99) >= 56);
        end
        2: begin
          out_ready <= ($urandom_range(0, 99) >= 32);
        end
        default: begin
          out_ready <= 1'b1;
        end
      endcase
    end
  end

  task automatic offer(logic req_op, logic [TagW-1:0] tag, logic [SlotW-1:0] rel,
                       logic [StampW-1:0] stamp);
    int unsigned gap_pct;
    gap_pct = (idle_mode == 1) ? 32 : (idle_mode == 2) ? 56 : 0;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    op <= req_op;
    owner_tag <= tag;
    release_slot <= rel;
    now_stamp <= stamp;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [CfgW-1:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic random_request(int unsigned lim);
    int unsigned roll;
    logic [StampW-1:0] stamp;
    roll = $urandom_range(0, 99);
    stamp_now += $urandom_range(0, 3);
    stamp = ($urandom_range(0, 9) == 0) ? $urandom : stamp_now;
    if (roll < 58) begin
      offer(OP_ALLOC, tag_pool[$urandom_range(0, 7)], SlotW'($urandom), stamp);
    end else if (roll < 92) begin
      offer(OP_RELEASE, tag_pool[$urandom_range(0, 7)],
            SlotW'($urandom_range(0, lim - 1)), $urandom);
    end else begin
      offer(1'($urandom), TagW'($urandom), SlotW'($urandom), $urandom);
    end
  endtask

  initial begin
    logic [CfgW-1:0] phase_limit[10];
    int unsigned lim;
    phase_limit = '{5'd2, 5'd4, 5'd16, 5'd7, 5'd31, 5'd1, 5'd0, 5'd17, 5'd12, 5'd3};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    offer(OP_ALLOC, 8'h01, 4'h0, 32'd100);
    offer(OP_RELEASE, 8'h01, 4'h0, 32'd0);
    write_limit(5'd3);
    offer(OP_ALLOC, 8'hAA, 4'h0, 32'd5);
    offer(OP_ALLOC, 8'h55, 4'h0, 32'd5);
    offer(OP_ALLOC, 8'hFF, 4'h0, 32'hFFFF_FFFF);
    offer(OP_ALLOC, 8'h00, 4'h0, 32'd0);
    offer(OP_RELEASE, 8'h54, 4'h1, 32'd0);
    offer(OP_RELEASE, 8'h55, 4'h1, 32'd0);
    offer(OP_RELEASE, 8'h55, 4'h1, 32'd0);
    offer(OP_RELEASE, 8'h00, 4'hF, 32'd0);
    offer(OP_ALLOC, 8'h3C, 4'h0, 32'd7);
    write_limit(5'd1);
    offer(OP_ALLOC, 8'hC3, 4'hF, 32'd10);
    offer(OP_RELEASE, 8'hFF, 4'h2, 32'd0);
    write_limit(5'd0);
    offer(OP_ALLOC, 8'h11, 4'h0, 32'd0);
    offer(OP_RELEASE, 8'h3C, 4'h1, 32'd0);
    write_limit(5'd31);
    offer(OP_ALLOC, 8'h22, 4'h0, 32'd1);
    offer(OP_RELEASE, 8'h22, 4'h1, 32'd0);
    offer(OP_RELEASE, 8'h11, 4'h0, 32'd0);
    write_limit(5'd17);
    offer(OP_ALLOC, 8'hEE, 4'hA, 32'hFFFF_FFFE);
    offer(OP_RELEASE, 8'hEE, 4'h0, 32'd0);

    for (int p = 0; p < 10; p++) begin
      write_limit(phase_limit[p]);
      idle_mode = (p < 3) ? 1 : (p < 6) ? 2 : 0;
      lim = (phase_limit[p] == '0) ? 32'd1 : (phase_limit[p] > SlotSpan) ? SlotSpan
          : 32'(phase_limit[p]);
      foreach (tag_pool[k]) tag_pool[k] = TagW'($urandom);
      for (int n = 0; n < 150; n++) begin
        if (p == 1 && n == 40) hold_kick = 1'b1;
        if (p == 4 && n == 75) drain();
        random_request(lim);
      end
    end

    drain();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
